@@ sv/brs_pkg.sv @@
// Shared types and constants for the byte stream reassembler.
// No dependencies; imported by every module of the block but brs_queue.
package brs_pkg;

    localparam int IDX_W       = 64;
    localparam int DATA_W      = 8;
    localparam int SPACE_W     = 7;
    localparam int PEND_W      = 7;
    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 16;
    localparam int RES_STAGES  = 8;   // one index byte folded per stage

    // bit positions in the input tuser
    localparam int TU_BYTE_VALID = 0;
    localparam int TU_SEG_START  = 1;
    localparam int TU_LAST       = 2;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   stop_idx;
        logic [DATA_W-1:0]  data;
        logic               valid;
        logic               seg_start;
        logic               seg_end;
        logic               last;
        logic [SPACE_W-1:0] space;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              byte_valid;
        logic              closed;
        logic [PEND_W-1:0] pending;
        logic              last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_FIN,
        ST_CHECK,
        ST_RD,
        ST_PUSH,
        ST_STATUS
    } t_bstate;

endpackage

@@ sv/brs_front.sv @@
// Front end: accepts input items, decodes the stream fields and computes
// the slot (index mod CAPACITY) over a short pipeline. Uses brs_pkg.
module brs_front #(
    parameter int CAPACITY = 64,
    parameter int SW       = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_tvalid,
    output logic                               o_tready,
    input  logic [brs_pkg::IN_TDATA_W-1:0]     i_tdata,
    input  logic [brs_pkg::IN_TUSER_W-1:0]     i_tuser,
    input  logic                               i_tlast,
    output logic                               o_valid,
    input  logic                               i_ready,
    output brs_pkg::t_item                     o_item,
    output logic [SW-1:0]                      o_slot
);
    import brs_pkg::*;

    localparam int NS = RES_STAGES;
    localparam int VW = SW + 9;

    // one residue step: (r * 256 + b) mod CAPACITY, r < CAPACITY
    function automatic logic [SW-1:0] f_fold(input logic [SW-1:0] r,
                                             input logic [7:0] b);
        logic [VW-1:0] v;
        logic [VW-1:0] c;
        v = VW'({r, b});
        for (int k = 7; k >= 0; k--) begin
            c = VW'(CAPACITY) << k;
            if (v >= c) begin
                v = v - c;
            end
        end
        return v[SW-1:0];
    endfunction

    logic          r_v    [NS];
    t_item         r_item [NS];
    logic [SW-1:0] r_res  [NS];
    logic          en;
    t_item         in_item;

    assign en       = !r_v[NS-1] || i_ready;
    assign o_tready = en;
    assign o_valid  = r_v[NS-1];
    assign o_item   = r_item[NS-1];
    assign o_slot   = r_res[NS-1];

    always_comb begin
        in_item.idx       = i_tdata[IDX_W-1:0];
        in_item.data      = i_tdata[IDX_W +: DATA_W];
        in_item.space     = i_tdata[IDX_W+DATA_W +: SPACE_W];
        in_item.valid     = i_tuser[TU_BYTE_VALID];
        in_item.seg_start = i_tuser[TU_SEG_START];
        in_item.last      = i_tuser[TU_LAST];
        in_item.seg_end   = i_tlast;
        in_item.stop_idx  = in_item.valid ? in_item.idx + IDX_W'(1) : in_item.idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_tvalid;
            for (int s = 1; s < NS; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    // most significant index byte first
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item[0] <= in_item;
            r_res[0]  <= f_fold('0, in_item.idx[8*(NS-1) +: 8]);
            for (int s = 1; s < NS; s++) begin
                r_item[s] <= r_item[s-1];
                r_res[s]  <= f_fold(r_res[s-1], r_item[s-1].idx[8*(NS-1-s) +: 8]);
            end
        end
    end

endmodule

@@ sv/brs_queue.sv @@
// Short FIFO between the front end and the back end.
// Generic payload; no package dependency.
module brs_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_buf [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= f_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= f_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

endmodule

@@ sv/brs_back.sv @@
// Back end: window check and byte store, then the drain of contiguous bytes
// and the status for each segment end. Uses brs_pkg.
module brs_back #(
    parameter int CAPACITY = 64,
    parameter int SW       = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  brs_pkg::t_item     i_item,
    input  logic [SW-1:0]      i_slot,
    output logic               o_valid,
    input  logic               i_ready,
    output brs_pkg::t_result   o_res
);
    import brs_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_bstate              r_state;
    t_bstate              n_state;
    logic [DATA_W-1:0]    r_mem [CAPACITY];
    logic [DATA_W-1:0]    r_rd_data;
    logic [CAPACITY-1:0]  r_present;
    logic [CW-1:0]        r_pending;
    logic [IDX_W-1:0]     r_next;
    logic [IDX_W-1:0]     r_width;     // window end minus next index
    logic [IDX_W-1:0]     r_end;
    logic                 r_end_known;
    logic                 r_closed;
    logic [SW-1:0]        r_next_slot;
    logic [SW-1:0]        r_scan;
    logic [SW-1:0]        r_rd_slot;
    logic [CW-1:0]        r_cnt;
    logic                 r_ov;
    t_result              r_out;

    logic                 pop;
    logic                 store;
    logic                 hit;
    logic                 out_free;
    logic                 load;
    logic                 closed_now;
    logic                 at_end;
    logic [SPACE_W-1:0]   sp;
    logic [IDX_W-1:0]     width_eff;
    logic [IDX_W-1:0]     off;

    function automatic logic [SW-1:0] f_wrap(input logic [SW-1:0] s);
        return (s == SW'(CAPACITY - 1)) ? '0 : s + SW'(1);
    endfunction

    assign o_pop   = pop;
    assign o_valid = r_ov;
    assign o_res   = r_out;

    always_comb begin
        sp = (i_item.space > SPACE_W'(CAPACITY)) ? SPACE_W'(CAPACITY) : i_item.space;
        width_eff  = i_item.seg_start ? IDX_W'(sp) : r_width;
        off        = i_item.idx - r_next;
        closed_now = r_closed || (i_item.last && (i_item.stop_idx == r_next));
        at_end     = r_end_known && (r_next == r_end) && (r_pending == '0);
        hit        = (r_cnt != CAP_C) && r_present[r_scan];
        out_free   = !r_ov || i_ready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && i_item.seg_end) begin
                    n_state = closed_now ? ST_STATUS : ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (!hit) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:   n_state = ST_CHECK;
            ST_CHECK: n_state = (r_cnt == '0) ? ST_STATUS : ST_RD;
            ST_RD:    n_state = ST_PUSH;
            ST_PUSH: begin
                if (out_free) begin
                    n_state = (r_cnt == CW'(1)) ? ST_IDLE : ST_RD;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop   = (r_state == ST_IDLE) && i_valid;
        store = pop && i_item.valid && !r_closed && (off < width_eff);
        load  = ((r_state == ST_PUSH) || (r_state == ST_STATUS)) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_present   <= '0;
            r_pending   <= '0;
            r_next      <= '0;
            r_width     <= '0;
            r_end       <= '0;
            r_end_known <= 1'b0;
            r_closed    <= 1'b0;
            r_next_slot <= '0;
            r_cnt       <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (pop && i_item.seg_start) begin
                        r_width <= width_eff;
                    end
                    if (store) begin
                        r_present[i_slot] <= 1'b1;
                        if (!r_present[i_slot]) begin
                            r_pending <= r_pending + CW'(1);
                        end
                    end
                    if (pop && i_item.seg_end) begin
                        if (i_item.last) begin
                            if (i_item.stop_idx == r_next) begin
                                r_closed <= 1'b1;
                            end else begin
                                r_end       <= i_item.stop_idx;
                                r_end_known <= 1'b1;
                            end
                        end
                        r_cnt <= '0;
                    end
                end
                ST_COUNT: begin
                    // drained slots are cleared as the scan passes them
                    if (hit) begin
                        r_present[r_scan] <= 1'b0;
                        r_cnt             <= r_cnt + CW'(1);
                    end
                end
                ST_FIN: begin
                    r_next      <= r_next + IDX_W'(r_cnt);
                    r_width     <= r_width - IDX_W'(r_cnt);
                    r_pending   <= r_pending - r_cnt;
                    r_next_slot <= r_scan;
                end
                ST_CHECK: begin
                    if (at_end) begin
                        r_closed <= 1'b1;
                    end
                end
                ST_RD: begin
                end
                ST_PUSH: begin
                    if (out_free) begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                ST_STATUS: begin
                end
                default: begin
                end
            endcase
        end
    end

    // scan and read pointers, output payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && pop && i_item.seg_end) begin
            r_scan    <= r_next_slot;
            r_rd_slot <= r_next_slot;
        end else if ((r_state == ST_COUNT) && hit) begin
            r_scan <= f_wrap(r_scan);
        end else if ((r_state == ST_PUSH) && out_free) begin
            r_rd_slot <= f_wrap(r_rd_slot);
        end
        if (load) begin
            r_out.out_byte   <= (r_state == ST_PUSH) ? r_rd_data : '0;
            r_out.byte_valid <= (r_state == ST_PUSH);
            r_out.closed     <= r_closed;
            r_out.pending    <= PEND_W'(r_pending);
            r_out.last       <= (r_state == ST_STATUS) || (r_cnt == CW'(1));
        end
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[i_slot] <= i_item.data;
        end
        if (r_state == ST_RD) begin
            r_rd_data <= r_mem[r_rd_slot];
        end
    end

endmodule

@@ sv/byte_stream_reassembler.sv @@
// Top level of the byte stream reassembler: front end, item queue, back end.
// Depends on brs_pkg, brs_front, brs_queue and brs_back.
//
// Usage:
//  s_axis carries one byte item per transfer; tlast marks the last item of a
//  substring (segment end). A segment end produces one or more results on
//  m_axis: one per drained in-order byte, or a single status-only result
//  when nothing drains. m_axis_tlast marks the final result of that run.
//  An item passes an 8-stage slot pipeline into a 4-entry queue. Items
//  without segment end are stored at one per cycle while the back end is
//  idle. A segment end scans the contiguous stored bytes, updates next
//  index (ST_FIN) and close state (ST_CHECK), then drains each byte by a
//  store read and then the output register, or loads a status result; a
//  closed stream skips the scan. The byte store has a single read port.
//  Reset: synchronous, active low; the presence bits, counters and close
//  state clear at once, the byte store holds no reset and needs no pass.
//  A stalled receiver holds the output register; the queue keeps taking
//  items until it fills, then s_axis_tready drops.
module byte_stream_reassembler #(
    parameter int CAPACITY = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // byte_index[63:0], data_byte[71:64], space_available[78:72], zero [79]
    input  logic [brs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // byte_valid[0], segment_start[1], stream_last[2]
    input  logic [brs_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_byte[7:0], stream_closed[8], pending_bytes[15:9]
    output logic [brs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // out_byte_valid[0]
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);
    import brs_pkg::*;

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int QW = $bits(t_item) + SW;

    logic          f_valid;
    logic          q_ready;
    t_item         f_item;
    logic [SW-1:0] f_slot;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_data;
    t_item         b_item;
    logic [SW-1:0] b_slot;
    t_result       b_res;

    brs_front #(
        .CAPACITY (CAPACITY),
        .SW       (SW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_tlast  (s_axis_tlast),
        .o_valid  (f_valid),
        .i_ready  (q_ready),
        .o_item   (f_item),
        .o_slot   (f_slot)
    );

    brs_queue #(
        .W     (QW),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_item, f_slot}),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign b_item = q_data[QW-1:SW];
    assign b_slot = q_data[SW-1:0];

    brs_back #(
        .CAPACITY (CAPACITY),
        .SW       (SW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_item  (b_item),
        .i_slot  (b_slot),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (b_res)
    );

    assign m_axis_tdata = {b_res.pending, b_res.closed, b_res.out_byte};
    assign m_axis_tuser = b_res.byte_valid;
    assign m_axis_tlast = b_res.last;

endmodule

@@ sv/brs_checker.sv @@
// Port-level checks on the reassembler output stream, bound to the top level.
// Depends on brs_pkg and byte_stream_reassembler.
module brs_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [brs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               m_axis_tuser,
    input  logic                               m_axis_tlast
);
    import brs_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // a status-only result is always the last of its run
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("status result not last of run");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("status result carries a byte");

    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:9] <= 7'd64))
        else $error("pending count out of range");

endmodule

bind byte_stream_reassembler brs_checker u_brs_checker (.*);
